// ===== src/fvw_pkg.sv =====
// Package for the face vertex weld / UV bounds unit.
// Holds shared constants, register indexes and the front-to-back queue entry type.
// No dependencies.
package fvw_pkg;

  localparam int MaxVertsDefault  = 64;
  localparam int CoordBitsDefault = 24;
  localparam int CfgIdxBits       = 3;
  localparam int CfgDataBits      = 64;
  localparam int ScaleBits        = 16;
  localparam int SizeBits         = 13;
  localparam int AxisBits         = 16;

  localparam logic [CfgIdxBits-1:0] RegUAxis  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegVAxis  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegScaleU = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegScaleV = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegTexW   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegTexH   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegNoMesh = 3'd6;

  // Queue entry: one accepted corner. Sized for the widest coordinate setting.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } corner_t;

endpackage

// ===== src/fvw_fifo.sv =====
// Short queue between the corner front end and the weld/projection back end.
// Depends on fvw_pkg for the entry type.
module fvw_fifo
  import fvw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  corner_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output corner_t data_o
);

  corner_t     mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

// ===== src/fvw_div.sv =====
// Restoring signed divider, one quotient bit per cycle.
// Depends on fvw_pkg.
module fvw_div
  import fvw_pkg::*;
#(
  parameter int NumBits = 64,
  parameter int DenBits = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic signed [DenBits-1:0] den_i,
  output logic                      done_o,
  output logic signed [NumBits-1:0] quo_o
);

  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] n_q;
  logic [DenBits-1:0] d_q;
  logic [DenBits:0]   r_q;
  logic               neg_q, busy_q;
  logic [CntBits-1:0] cnt_q;
  logic [DenBits:0]   r_sh, r_sub;

  assign r_sh  = {r_q[DenBits-1:0], n_q[NumBits-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign quo_o = neg_q ? -n_q : n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(NumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i[NumBits-1] ? -num_i : num_i;
      d_q   <= den_i[DenBits-1] ? -den_i : den_i;
      neg_q <= num_i[NumBits-1] ^ den_i[DenBits-1];
      r_q   <= '0;
    end else if (busy_q) begin
      if (!r_sub[DenBits]) begin
        r_q <= r_sub;
        n_q <= {n_q[NumBits-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        n_q <= {n_q[NumBits-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/fvw_back.sv =====
// Back end: serial table search, append, bounding box and UV projection.
// Depends on fvw_pkg and fvw_div.
module fvw_back
  import fvw_pkg::*;
#(
  parameter int MaxVerts  = MaxVertsDefault,
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  corner_t                     corner_i,
  output logic                        pop_o,
  input  logic [63:0]                 u_reg_i,
  input  logic [63:0]                 v_reg_i,
  input  logic signed [ScaleBits-1:0] scale_u_i,
  input  logic signed [ScaleBits-1:0] scale_v_i,
  input  logic [SizeBits-1:0]         tex_w_i,
  input  logic [SizeBits-1:0]         tex_h_i,
  input  logic                        no_mesh_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [5:0]                  vertex_index_o,
  output logic                        is_new_o,
  output logic                        table_full_o,
  output logic signed [CoordBits-1:0] tex_u_o,
  output logic signed [CoordBits-1:0] tex_v_o,
  output logic                        face_done_o,
  output logic signed [CoordBits-1:0] min_x_o,
  output logic signed [CoordBits-1:0] min_y_o,
  output logic signed [CoordBits-1:0] min_z_o,
  output logic signed [CoordBits-1:0] max_x_o,
  output logic signed [CoordBits-1:0] max_y_o,
  output logic signed [CoordBits-1:0] max_z_o
);

  localparam int IdxBits = $clog2(MaxVerts);
  localparam int CntBits = $clog2(MaxVerts + 1);
  localparam int PosBits = 3 * CoordBits;
  localparam int DotBits = CoordBits + AxisBits + 2;
  localparam int NumBits = 64;
  localparam int DenBits = ScaleBits + SizeBits + 1;
  localparam logic signed [CoordBits-1:0] LimHi = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] LimLo = {1'b1, {(CoordBits-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CMP, S_MUL, S_SUM, S_DIVU, S_WAITU, S_DIVV, S_WAITV, S_OUT
  } state_e;

  state_e state_q;
  logic [PosBits-1:0] mem [MaxVerts];
  logic [PosBits-1:0] rd_q;
  logic [CntBits-1:0] count_q, k_q;
  logic signed [CoordBits-1:0] px_q, py_q, pz_q;
  logic last_q;
  logic signed [CoordBits-1:0] bmin_q [3];
  logic signed [CoordBits-1:0] bmax_q [3];
  logic signed [DotBits-1:0] pu_q [3];
  logic signed [DotBits-1:0] pv_q [3];
  logic signed [NumBits-1:0] numu_q, numv_q;
  logic signed [DenBits-1:0] denu_q, denv_q;
  logic signed [NumBits-1:0] qu_q;

  logic div_start, div_done;
  logic signed [NumBits-1:0] div_num, div_quo;
  logic signed [DenBits-1:0] div_den;

  fvw_div #(.NumBits(NumBits), .DenBits(DenBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign div_start = (state_q == S_DIVU) || (state_q == S_DIVV);
  assign div_num   = (state_q == S_DIVU) ? numu_q : numv_q;
  assign div_den   = (state_q == S_DIVU) ? denu_q : denv_q;

  function automatic logic signed [CoordBits-1:0] sat_f(input logic signed [NumBits-1:0] x);
    if (x > NumBits'(LimHi)) return LimHi;
    if (x < NumBits'(LimLo)) return LimLo;
    return x[CoordBits-1:0];
  endfunction

  // Quotient with the zero-divisor rule folded in.
  function automatic logic signed [NumBits-1:0] quo_f(
      input logic signed [NumBits-1:0] num, input logic signed [DenBits-1:0] den,
      input logic signed [NumBits-1:0] q);
    if (den != '0) return q;
    if (num > 0) return NumBits'(LimHi);
    if (num < 0) return NumBits'(LimLo);
    return '0;
  endfunction

  logic [PosBits-1:0] pos_w;
  logic hit;
  assign pos_w = {pz_q, py_q, px_q};
  assign hit   = (rd_q == pos_w);

  logic signed [ScaleBits-1:0] offu, offv;
  assign offu = u_reg_i[63:48];
  assign offv = v_reg_i[63:48];

  // Append exactly when the FSM takes its append branch; rd_q is stale on an empty table.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP && !(k_q < count_q && hit) && k_q + 1'b1 >= count_q
        && count_q < CntBits'(MaxVerts))
      mem[count_q[IdxBits-1:0]] <= pos_w;
    rd_q <= mem[k_q[IdxBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_o <= 1'b0;
      k_q     <= '0;
      px_q    <= '0;
      py_q    <= '0;
      pz_q    <= '0;
      last_q  <= 1'b0;
      vertex_index_o <= '0;
      is_new_o       <= 1'b0;
      table_full_o   <= 1'b0;
      tex_u_o        <= '0;
      tex_v_o        <= '0;
      face_done_o    <= 1'b0;
      min_x_o <= '0; min_y_o <= '0; min_z_o <= '0;
      max_x_o <= '0; max_y_o <= '0; max_z_o <= '0;
      numu_q <= '0;
      numv_q <= '0;
      denu_q <= '0;
      denv_q <= '0;
      qu_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= LimHi;
        bmax_q[i] <= LimLo;
        pu_q[i]   <= '0;
        pv_q[i]   <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!empty_i && !valid_o) begin
            px_q <= corner_i.x[CoordBits-1:0];
            py_q <= corner_i.y[CoordBits-1:0];
            pz_q <= corner_i.z[CoordBits-1:0];
            last_q <= corner_i.last;
            k_q <= '0;
            vertex_index_o <= '0;
            is_new_o <= 1'b0;
            table_full_o <= 1'b0;
            tex_u_o <= '0;
            tex_v_o <= '0;
            state_q <= no_mesh_i ? S_OUT : (count_q == '0 ? S_CMP : S_READ);
          end
        end
        S_READ: state_q <= S_CMP;
        S_CMP: begin
          if (k_q < count_q && hit) begin
            vertex_index_o <= 6'(k_q);
            state_q <= S_OUT;
          end else if (k_q + 1'b1 < count_q) begin
            k_q <= k_q + 1'b1;
            state_q <= S_READ;
          end else if (count_q >= CntBits'(MaxVerts)) begin
            table_full_o <= 1'b1;
            state_q <= S_OUT;
          end else begin
            vertex_index_o <= 6'(count_q);
            is_new_o <= 1'b1;
            count_q <= count_q + 1'b1;
            if (px_q < bmin_q[0]) bmin_q[0] <= px_q;
            if (py_q < bmin_q[1]) bmin_q[1] <= py_q;
            if (pz_q < bmin_q[2]) bmin_q[2] <= pz_q;
            if (px_q > bmax_q[0]) bmax_q[0] <= px_q;
            if (py_q > bmax_q[1]) bmax_q[1] <= py_q;
            if (pz_q > bmax_q[2]) bmax_q[2] <= pz_q;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pu_q[0] <= DotBits'(px_q * $signed(u_reg_i[15:0]));
          pu_q[1] <= DotBits'(py_q * $signed(u_reg_i[31:16]));
          pu_q[2] <= DotBits'(pz_q * $signed(u_reg_i[47:32]));
          pv_q[0] <= DotBits'(px_q * $signed(v_reg_i[15:0]));
          pv_q[1] <= DotBits'(py_q * $signed(v_reg_i[31:16]));
          pv_q[2] <= DotBits'(pz_q * $signed(v_reg_i[47:32]));
          denu_q <= DenBits'(scale_u_i * $signed({1'b0, tex_w_i}));
          denv_q <= DenBits'(scale_v_i * $signed({1'b0, tex_h_i}));
          state_q <= S_SUM;
        end
        S_SUM: begin
          numu_q <= (NumBits'(pu_q[0] + pu_q[1] + pu_q[2]) <<< 2)
                  + (NumBits'(offu * scale_u_i) <<< 16);
          numv_q <= (NumBits'(pv_q[0] + pv_q[1] + pv_q[2]) <<< 2)
                  + (NumBits'(offv * scale_v_i) <<< 16);
          state_q <= S_DIVU;
        end
        S_DIVU: state_q <= S_WAITU;
        S_WAITU: if (div_done) begin
          qu_q <= quo_f(numu_q, denu_q, div_quo);
          state_q <= S_DIVV;
        end
        S_DIVV: state_q <= S_WAITV;
        S_WAITV: if (div_done) begin
          tex_u_o <= sat_f(qu_q);
          tex_v_o <= sat_f(NumBits'(65536) - quo_f(numv_q, denv_q, div_quo));
          state_q <= S_OUT;
        end
        S_OUT: begin
          face_done_o <= last_q;
          if (last_q) begin
            min_x_o <= no_mesh_i ? LimHi : bmin_q[0];
            min_y_o <= no_mesh_i ? LimHi : bmin_q[1];
            min_z_o <= no_mesh_i ? LimHi : bmin_q[2];
            max_x_o <= no_mesh_i ? LimLo : bmax_q[0];
            max_y_o <= no_mesh_i ? LimLo : bmax_q[1];
            max_z_o <= no_mesh_i ? LimLo : bmax_q[2];
            count_q <= '0;
            for (int i = 0; i < 3; i++) begin
              bmin_q[i] <= LimHi;
              bmax_q[i] <= LimLo;
            end
          end else begin
            min_x_o <= '0; min_y_o <= '0; min_z_o <= '0;
            max_x_o <= '0; max_y_o <= '0; max_z_o <= '0;
          end
          valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (valid_o && ready_i) valid_o <= 1'b0;
    end
  end

  assign pop_o = (state_q == S_IDLE) && !empty_i && !valid_o;

endmodule

// ===== src/face_vertex_weld_uv_bounds_unit.sv =====
// Top level of the face vertex weld / UV bounds unit.
// Depends on fvw_pkg, fvw_fifo, fvw_back (and fvw_div below it).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  corner   | corner_valid_i/ready_o    | pos_x/y/z_i, last_corner_i
//  result   | result_valid_o/ready_i    | vertex_index_o .. max_z_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// The back end pops a corner and searches the vertex table one entry at a time. A match
// reports that entry; a miss appends the corner and runs two 64-step divisions, U then V,
// on the shared divider; a miss on a full table, or mesh building off, goes straight to
// the result. A two-entry queue decouples corner transfers from the back end, which holds
// its result register until the transfer downstream. Reset clears control state and
// returns the configuration registers to their defaults; the vertex table needs no
// clearing.
module face_vertex_weld_uv_bounds_unit
  import fvw_pkg::*;
#(
  parameter int MaxVerts  = MaxVertsDefault,
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        corner_valid_i,
  output logic                        corner_ready_o,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] pos_z_i,
  input  logic                        last_corner_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [5:0]                  vertex_index_o,
  output logic                        is_new_o,
  output logic                        table_full_o,
  output logic signed [CoordBits-1:0] tex_u_o,
  output logic signed [CoordBits-1:0] tex_v_o,
  output logic                        face_done_o,
  output logic signed [CoordBits-1:0] min_x_o,
  output logic signed [CoordBits-1:0] min_y_o,
  output logic signed [CoordBits-1:0] min_z_o,
  output logic signed [CoordBits-1:0] max_x_o,
  output logic signed [CoordBits-1:0] max_y_o,
  output logic signed [CoordBits-1:0] max_z_o,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i
);

  logic [63:0] u_reg_q, v_reg_q;
  logic signed [ScaleBits-1:0] scale_u_q, scale_v_q;
  logic [SizeBits-1:0] tex_w_q, tex_h_q;
  logic no_mesh_q;

  // Configuration writes land directly; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_reg_q   <= '0;
      v_reg_q   <= '0;
      scale_u_q <= 16'sd256;
      scale_v_q <= 16'sd256;
      tex_w_q   <= 13'd64;
      tex_h_q   <= 13'd64;
      no_mesh_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUAxis:  u_reg_q   <= cfg_data_i;
        RegVAxis:  v_reg_q   <= cfg_data_i;
        RegScaleU: scale_u_q <= cfg_data_i[ScaleBits-1:0];
        RegScaleV: scale_v_q <= cfg_data_i[ScaleBits-1:0];
        RegTexW:   tex_w_q   <= cfg_data_i[SizeBits-1:0];
        RegTexH:   tex_h_q   <= cfg_data_i[SizeBits-1:0];
        RegNoMesh: no_mesh_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front end: pack the corner and push it into the queue on each transfer.
  corner_t in_w, head_w;
  logic q_full, q_empty, pop_w, push_w;

  assign in_w.x    = 32'(pos_x_i);
  assign in_w.y    = 32'(pos_y_i);
  assign in_w.z    = 32'(pos_z_i);
  assign in_w.last = last_corner_i;
  assign corner_ready_o = !q_full;
  assign push_w = corner_valid_i && !q_full;

  fvw_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push_w), .data_i(in_w), .full_o(q_full),
    .pop_i(pop_w), .empty_o(q_empty), .data_o(head_w)
  );

  fvw_back #(.MaxVerts(MaxVerts), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .corner_i(head_w), .pop_o(pop_w),
    .u_reg_i(u_reg_q), .v_reg_i(v_reg_q), .scale_u_i(scale_u_q), .scale_v_i(scale_v_q),
    .tex_w_i(tex_w_q), .tex_h_i(tex_h_q), .no_mesh_i(no_mesh_q),
    .valid_o(result_valid_o), .ready_i(result_ready_i),
    .vertex_index_o, .is_new_o, .table_full_o, .tex_u_o, .tex_v_o, .face_done_o,
    .min_x_o, .min_y_o, .min_z_o, .max_x_o, .max_y_o, .max_z_o
  );

endmodule

// ===== sim/face_vertex_weld_uv_bounds_unit_tb.sv =====
// Self-checking testbench for face_vertex_weld_uv_bounds_unit.
// Drives faces of corners with random idling and checks each weld result against an
// in-bench model of the vertex table, planar UV projection and bounding box. Uses fvw_pkg.
module face_vertex_weld_uv_bounds_unit_tb;
  import fvw_pkg::*;

  localparam int          NVerts    = 64;
  localparam longint      CoordHi   = 64'sd8388607;
  localparam longint      CoordLo   = -64'sd8388608;
  localparam int unsigned CycleCap  = 3000000;
  localparam int          DrainWait = 300;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               last;
  } corner_item_t;

  typedef struct packed {
    logic [5:0]         idx;
    logic               is_new;
    logic               full;
    logic signed [23:0] u;
    logic signed [23:0] v;
    logic               done;
    logic signed [23:0] lo_x;
    logic signed [23:0] lo_y;
    logic signed [23:0] lo_z;
    logic signed [23:0] hi_x;
    logic signed [23:0] hi_y;
    logic signed [23:0] hi_z;
  } weld_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   corner_valid_i;
  logic                   corner_ready_o;
  logic signed [23:0]     pos_x_i, pos_y_i, pos_z_i;
  logic                   last_corner_i;
  logic                   result_valid_o;
  logic                   result_ready_i;
  logic [5:0]             vertex_index_o;
  logic                   is_new_o, table_full_o, face_done_o;
  logic signed [23:0]     tex_u_o, tex_v_o;
  logic signed [23:0]     min_x_o, min_y_o, min_z_o, max_x_o, max_y_o, max_z_o;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  face_vertex_weld_uv_bounds_unit dut (.*);

  // Bench state: stimulus backlog, expected results, register shadow and the weld model.
  corner_item_t     corner_backlog[$];
  weld_result_t     weld_expected[$];
  logic [63:0]      reg_shadow[7];
  longint           vert_x[NVerts], vert_y[NVerts], vert_z[NVerts];
  int               vert_count;
  longint           box_lo[3], box_hi[3];
  int unsigned      err_count;
  int unsigned      cycle_count;
  bit               corner_taken, result_taken;
  bit               idle_on;
  bit               hold_req;
  int               hold_left, send_gap, rx_stall;
  logic             nxt_valid;
  corner_item_t     taken_item;
  weld_result_t     taken_exp, model_out;

  always begin
    #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_coord(longint val);
    if (val > CoordHi) return CoordHi;
    if (val < CoordLo) return CoordLo;
    return val;
  endfunction

  // Raw Q7.16 quotient of the planar projection; a zero divisor saturates by sign.
  function automatic longint uv_quot(longint px, longint py, longint pz,
                                     logic [63:0] axis, logic [15:0] sc, logic [12:0] sz);
    longint d, off, s, num, den;
    d   = px * longint'($signed(axis[15:0])) + py * longint'($signed(axis[31:16]))
        + pz * longint'($signed(axis[47:32]));
    off = longint'($signed(axis[63:48]));
    s   = longint'($signed(sc));
    num = d * 4 + off * s * 65536;
    den = s * longint'(sz);
    if (den == 0) begin
      if (num > 0) return CoordHi;
      if (num < 0) return CoordLo;
      return 0;
    end
    return num / den;
  endfunction

  function automatic void clear_face();
    vert_count = 0;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = CoordHi;
      box_hi[i] = CoordLo;
    end
  endfunction

  // Weld one corner: look it up, append it when new, and report bounds on the last corner.
  function automatic weld_result_t weld_corner(corner_item_t c);
    weld_result_t r;
    longint       p[3];
    bit           found;
    bit           nomesh;
    r      = '0;
    p[0]   = c.x;
    p[1]   = c.y;
    p[2]   = c.z;
    nomesh = reg_shadow[RegNoMesh][0];
    if (!nomesh) begin
      found = 0;
      for (int k = 0; k < vert_count; k++) begin
        if (!found && vert_x[k] == p[0] && vert_y[k] == p[1] && vert_z[k] == p[2]) begin
          found = 1;
          r.idx = k[5:0];
        end
      end
      if (!found) begin
        if (vert_count >= NVerts) begin
          r.full = 1;
        end else begin
          vert_x[vert_count] = p[0];
          vert_y[vert_count] = p[1];
          vert_z[vert_count] = p[2];
          r.idx    = vert_count[5:0];
          r.is_new = 1;
          vert_count++;
          for (int i = 0; i < 3; i++) begin
            if (p[i] < box_lo[i]) box_lo[i] = p[i];
            if (p[i] > box_hi[i]) box_hi[i] = p[i];
          end
          r.u = 24'(clamp_coord(uv_quot(p[0], p[1], p[2], reg_shadow[RegUAxis],
                                        reg_shadow[RegScaleU][15:0], reg_shadow[RegTexW][12:0])));
          r.v = 24'(clamp_coord(65536 - uv_quot(p[0], p[1], p[2], reg_shadow[RegVAxis],
                                        reg_shadow[RegScaleV][15:0], reg_shadow[RegTexH][12:0])));
        end
      end
    end
    r.done = c.last;
    if (c.last) begin
      r.lo_x = nomesh ? 24'(CoordHi) : 24'(box_lo[0]);
      r.lo_y = nomesh ? 24'(CoordHi) : 24'(box_lo[1]);
      r.lo_z = nomesh ? 24'(CoordHi) : 24'(box_lo[2]);
      r.hi_x = nomesh ? 24'(CoordLo) : 24'(box_hi[0]);
      r.hi_y = nomesh ? 24'(CoordLo) : 24'(box_hi[1]);
      r.hi_z = nomesh ? 24'(CoordLo) : 24'(box_hi[2]);
      clear_face();
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      err_count++;
    end
  endfunction

  // Monitor: count cycles, record corner transfers and check result transfers.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("face_vertex_weld_uv_bounds_unit_tb: errors");
      $finish;
    end else begin
      if (rst_ni && corner_valid_i && corner_ready_o) begin
        taken_item = corner_backlog.pop_front();
        model_out  = weld_corner(taken_item);
        weld_expected.insert(weld_expected.size(), model_out);
        corner_taken = 1;
      end
      if (rst_ni && result_valid_o && result_ready_i) begin
        result_taken = 1;
        if (weld_expected.size() == 0) begin
          $error("result transfer with no expectation waiting");
          err_count++;
        end else begin
          taken_exp = weld_expected.pop_front();
          check_field("vertex_index", taken_exp.idx, vertex_index_o);
          check_field("is_new", taken_exp.is_new, is_new_o);
          check_field("table_full", taken_exp.full, table_full_o);
          check_field("tex_u", taken_exp.u, tex_u_o);
          check_field("tex_v", taken_exp.v, tex_v_o);
          check_field("face_done", taken_exp.done, face_done_o);
          check_field("min_x", taken_exp.lo_x, min_x_o);
          check_field("min_y", taken_exp.lo_y, min_y_o);
          check_field("min_z", taken_exp.lo_z, min_z_o);
          check_field("max_x", taken_exp.hi_x, max_x_o);
          check_field("max_y", taken_exp.hi_y, max_y_o);
          check_field("max_z", taken_exp.hi_z, max_z_o);
        end
      end
    end
  end

  // Driver: offer the backlog front, holding valid and payload until the transfer.
  always @(negedge clk_i) begin
    nxt_valid = corner_valid_i;
    if (corner_taken) begin
      corner_taken = 0;
      nxt_valid    = 0;
      send_gap     = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (rst_ni && !nxt_valid && corner_backlog.size() > 0) begin
      if (send_gap > 0) begin
        send_gap--;
      end else begin
        nxt_valid = 1;
        pos_x_i       <= corner_backlog[0].x;
        pos_y_i       <= corner_backlog[0].y;
        pos_z_i       <= corner_backlog[0].z;
        last_corner_i <= corner_backlog[0].last;
      end
    end
    corner_valid_i <= nxt_valid;
  end

  // Receiver: while idling is on, stall at random after each transfer; a requested hold-off lets the block fill.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (result_taken) begin
      result_taken = 0;
      rx_stall     = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= rst_ni;
    end
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'(CoordHi);
      1: return 24'(CoordLo);
      2: return 24'($signed($urandom_range(0, 4096)) - 2048);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegScaleU, RegScaleV: reg_shadow[idx] = {48'd0, data[15:0]};
      RegTexW, RegTexH:     reg_shadow[idx] = {51'd0, data[12:0]};
      RegNoMesh:            reg_shadow[idx] = {63'd0, data[0]};
      default:              reg_shadow[idx] = data;
    endcase
  endtask

  // Hold until every corner has gone in and every result has come back.
  task automatic wait_drained();
    while (corner_backlog.size() != 0 || weld_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic push_corner(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic last);
    corner_item_t c;
    c.x    = x;
    c.y    = y;
    c.z    = z;
    c.last = last;
    corner_backlog.insert(corner_backlog.size(), c);
  endtask

  // One face of n corners; about one in four repeats an earlier corner of the face.
  task automatic push_face(int n);
    corner_item_t seen[$];
    corner_item_t c;
    for (int i = 0; i < n; i++) begin
      if (seen.size() > 0 && $urandom_range(0, 3) == 0) begin
        c = seen[$urandom_range(0, seen.size() - 1)];
      end else begin
        c.x = rand_coord();
        c.y = rand_coord();
        c.z = rand_coord();
        seen.insert(seen.size(), c);
      end
      c.last = (i == n - 1);
      corner_backlog.insert(corner_backlog.size(), c);
    end
  endtask

  task automatic random_config(int sel);
    logic [63:0] u_reg, v_reg;
    logic [15:0] su, sv;
    logic [12:0] tw, th;
    u_reg = {rand_axis(), rand_axis(), rand_axis(), rand_axis()};
    v_reg = {rand_axis(), rand_axis(), rand_axis(), rand_axis()};
    su = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 1024)) : 16'($urandom());
    sv = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 1024)) : 16'($urandom());
    tw = 13'($urandom_range(1, 4096));
    th = 13'($urandom_range(1, 4096));
    case (sel)
      0: begin su = 16'h8000; sv = 16'h7fff; tw = 13'd4096; th = 13'd1; end
      1: begin su = 16'h0000; sv = 16'h0100; tw = 13'd64;   th = 13'd0; end
      2: begin su = 16'hffff; sv = 16'h0000; tw = 13'h1fff; th = 13'h1fff; end
      default: ;
    endcase
    cfg_write(RegUAxis, u_reg);
    cfg_write(RegVAxis, v_reg);
    cfg_write(RegScaleU, {48'd0, su});
    cfg_write(RegScaleV, {48'd0, sv});
    cfg_write(RegTexW, {51'd0, tw});
    cfg_write(RegTexH, {51'd0, th});
    cfg_write(RegNoMesh, {63'd0, sel == 3});
  endtask

  initial begin
    int quota;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    corner_valid_i = 1'b0;
    result_ready_i = 1'b0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    last_corner_i  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    err_count      = 0;
    cycle_count    = 0;
    corner_taken   = 0;
    result_taken   = 0;
    hold_req       = 0;
    hold_left      = 0;
    send_gap       = 0;
    rx_stall       = 0;
    idle_on        = 1;
    reg_shadow[RegUAxis]  = 64'd0;
    reg_shadow[RegVAxis]  = 64'd0;
    reg_shadow[RegScaleU] = 64'd256;
    reg_shadow[RegScaleV] = 64'd256;
    reg_shadow[RegTexW]   = 64'd64;
    reg_shadow[RegTexH]   = 64'd64;
    reg_shadow[RegNoMesh] = 64'd0;
    clear_face();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: field extremes, a repeated corner, a repeat as last corner.
    push_corner(24'(CoordHi), 24'(CoordHi), 24'(CoordHi), 1'b0);
    push_corner(24'(CoordLo), 24'(CoordLo), 24'(CoordLo), 1'b0);
    push_corner(24'sd0, 24'sd0, 24'sd0, 1'b0);
    push_corner(24'(CoordHi), 24'(CoordHi), 24'(CoordHi), 1'b0);
    push_corner(24'sd0, 24'sd0, 24'sd0, 1'b1);
    push_corner(24'sd256, -24'sd256, 24'sd1, 1'b1);
    wait_drained();
    cfg_write(RegUAxis, {16'sd3, 16'sd0, 16'sd0, 16'sd16384});
    cfg_write(RegVAxis, {-16'sd2, 16'sd0, 16'sd16384, 16'sd0});
    push_corner(24'sd2560, 24'sd512, -24'sd128, 1'b0);
    push_corner(-24'sd2560, 24'sd100, 24'sd7, 1'b0);
    wait_drained();
    // Switch mesh building off in the middle of a face: its last corner reports empty bounds.
    cfg_write(RegNoMesh, 64'd1);
    push_corner(24'sd5, 24'sd6, 24'sd7, 1'b1);
    push_corner(24'sd1, 24'sd2, 24'sd3, 1'b0);
    push_corner(24'sd1, 24'sd2, 24'sd3, 1'b1);
    wait_drained();
    cfg_write(RegNoMesh, 64'd0);
    push_face(66);
    wait_drained();

    // Random phases, each under its own configuration; each drains before the next.
    for (int ph = 0; ph < 10; ph++) begin
      random_config(ph);
      idle_on = (ph != 4);
      quota   = (ph == 3) ? 60 : 170;
      while (quota > 0) begin
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 8);
        push_face(n);
        quota -= n;
      end
      if (ph == 5) begin
        @(posedge clk_i);
        hold_req = 1;
      end
      wait_drained();
    end

    repeat (DrainWait) @(negedge clk_i);
    if (err_count == 0) begin
      $display("face_vertex_weld_uv_bounds_unit_tb: clean");
    end else begin
      $display("face_vertex_weld_uv_bounds_unit_tb: errors");
    end
    $finish;
  end

endmodule
